// ===== hw/rtl/cmas_pkg.sv =====
// ----------------------------------------------------------------------------
// cmas_pkg
// Shared types and constants for the control message AVP scanner.
// ----------------------------------------------------------------------------
package cmas_pkg;

    localparam int unsigned ADDR_W = 3;

    localparam logic [3:0]  HDR_BYTES   = 4'd12;
    localparam logic [9:0]  MIN_AVP     = 10'd6;
    localparam logic [9:0]  MIN_WORD    = 10'd8;
    localparam logic [9:0]  MIN_TWO     = 10'd10;
    localparam logic [15:0] RESULT_TYPE = 16'd1;

    // header byte positions of Ns and Nr
    localparam logic [3:0] HDR_NS_HI = 4'd8;
    localparam logic [3:0] HDR_NS_LO = 4'd9;
    localparam logic [3:0] HDR_NR_HI = 4'd10;
    localparam logic [3:0] HDR_NR_LO = 4'd11;

    // byte positions inside one AVP
    localparam logic [9:0] AVP_LEN_HI  = 10'd0;
    localparam logic [9:0] AVP_LEN_LO  = 10'd1;
    localparam logic [9:0] AVP_TYPE_HI = 10'd4;
    localparam logic [9:0] AVP_TYPE_LO = 10'd5;
    localparam logic [9:0] AVP_W1_HI   = 10'd6;
    localparam logic [9:0] AVP_W1_LO   = 10'd7;
    localparam logic [9:0] AVP_W2_HI   = 10'd8;
    localparam logic [9:0] AVP_W2_LO   = 10'd9;

    // finder status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_ABSENT    = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_PENDING   = 2'd3;

    // verdict codes
    localparam logic [1:0] VD_PASS    = 2'd0;
    localparam logic [1:0] VD_FAIL    = 2'd1;
    localparam logic [1:0] VD_PENDING = 2'd3;

    // register map, selected by paddr[2]
    localparam logic REG_LOOKUP_ATTR = 1'b0;

    typedef struct packed {
        logic        header_ok;
        logic [15:0] sequence_sent;
        logic [15:0] sequence_received;
        logic [1:0]  lookup_status;
        logic [15:0] lookup_value;
        logic [1:0]  result_status;
        logic [15:0] outcome_code;
        logic [15:0] detail_code;
        logic        result_verdict;
    } cmas_result_t;

endpackage

// ===== hw/rtl/control_message_avp_scanner.sv =====
// ----------------------------------------------------------------------------
// control_message_avp_scanner
// Scans a control message byte by byte and reports header sequence numbers,
// one looked-up attribute value and the Result Code AVP outcome.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   word
//  data      in         data_valid / data_stall     data_byte, last_byte
//  result    out        result_valid / result_stall header_ok .. result_verdict
//  config    in         APB psel/penable/pready     lookup_attr_type at 0x0
//
//  One byte per cycle while data_stall is low; the walker updates its state
//  as each byte leaves the input register.
//  A result word appears at the edge where the last byte leaves the input
//  register, and holds until taken.
//  A last byte waits in the input register only while the result register
//  is full and stalled; other bytes never wait.
//  Reset clears all per-message state and the lookup type register.
// ----------------------------------------------------------------------------
module control_message_avp_scanner
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cmas_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          data_valid,
    output logic                          data_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          header_ok,
    output logic [15:0]                   sequence_sent,
    output logic [15:0]                   sequence_received,
    output logic [1:0]                    lookup_status,
    output logic [15:0]                   lookup_value,
    output logic [1:0]                    result_status,
    output logic [15:0]                   outcome_code,
    output logic [15:0]                   detail_code,
    output logic                          result_verdict
);

    logic [15:0]            attr_reg, attr_next;
    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic                   out_valid_reg, out_valid_next;
    cmas_pkg::cmas_result_t out_reg;
    logic                   fire;
    logic                   load;
    logic                   res_valid;
    cmas_pkg::cmas_result_t res;

    assign pready = 1'b1;

    always_comb
    begin
        attr_next = attr_reg;
        prdata    = '0;
        unique case (paddr[2])
            cmas_pkg::REG_LOOKUP_ATTR:
            begin
                prdata = {16'h0000, attr_reg};
                if (psel && penable && pwrite)
                begin
                    attr_next = pwdata[15:0];
                end
            end
            default: ;
        endcase
    end

    assign fire       = in_valid_reg && (!in_last_reg || !out_valid_reg || !result_stall);
    assign data_stall = in_valid_reg && !fire;
    assign load       = data_valid && !data_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (load)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    cmas_walker u_walker
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .data_byte        (in_byte_reg),
        .last_byte        (in_last_reg),
        .lookup_attr_type (attr_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            attr_reg      <= attr_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign result_valid      = out_valid_reg;
    assign header_ok         = out_reg.header_ok;
    assign sequence_sent     = out_reg.sequence_sent;
    assign sequence_received = out_reg.sequence_received;
    assign lookup_status     = out_reg.lookup_status;
    assign lookup_value      = out_reg.lookup_value;
    assign result_status     = out_reg.result_status;
    assign outcome_code      = out_reg.outcome_code;
    assign detail_code       = out_reg.detail_code;
    assign result_verdict    = out_reg.result_verdict;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        data_stall |-> (in_valid_reg && in_last_reg && out_valid_reg))
        else $error("input stalled without a blocked last byte");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |-> !res_valid)
        else $error("result produced while result register is held");

    a_short_header: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !header_ok) |->
        (lookup_status == cmas_pkg::ST_MALFORMED && result_status == cmas_pkg::ST_MALFORMED
         && result_verdict && sequence_sent == 16'h0000))
        else $error("short header result inconsistent");

    a_lookup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && lookup_status != cmas_pkg::ST_FOUND) |-> (lookup_value == 16'h0000))
        else $error("lookup value set without a match");

    a_code_fails: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_status == cmas_pkg::ST_FOUND && outcome_code != 16'h0000)
        |-> result_verdict)
        else $error("nonzero result code with passing verdict");

endmodule

// ===== hw/rtl/cmas_walker.sv =====
// ----------------------------------------------------------------------------
// cmas_walker
// Per-message header capture, AVP walk and finder state; forms the result
// word on the last byte.
// ----------------------------------------------------------------------------
module cmas_walker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic [15:0]           lookup_attr_type,
    output logic                  res_valid,
    output cmas_pkg::cmas_result_t res
);

    logic [3:0]  hc_reg,       hc_next;
    logic [15:0] seq_sent_reg, seq_sent_next;
    logic [15:0] seq_recv_reg, seq_recv_next;
    logic [9:0]  idx_reg,      idx_next;
    logic [9:0]  len_reg,      len_next;
    logic [15:0] type_reg,     type_next;
    logic [15:0] w1_reg,       w1_next;
    logic [15:0] w2_reg,       w2_next;
    logic        broken_reg,   broken_next;
    logic [1:0]  ls_reg,       ls_next;
    logic [15:0] lword_reg,    lword_next;
    logic [1:0]  rs_reg,       rs_next;
    logic [15:0] rword_reg,    rword_next;
    logic [15:0] eword_reg,    eword_next;
    logic [1:0]  vs_reg,       vs_next;

    always_comb
    begin
        logic [10:0] idx_inc;
        logic [1:0]  ls;
        logic [1:0]  rs;
        logic [1:0]  vs;

        hc_next       = hc_reg;
        seq_sent_next = seq_sent_reg;
        seq_recv_next = seq_recv_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        type_next     = type_reg;
        w1_next       = w1_reg;
        w2_next       = w2_reg;
        broken_next   = broken_reg;
        ls_next       = ls_reg;
        lword_next    = lword_reg;
        rs_next       = rs_reg;
        rword_next    = rword_reg;
        eword_next    = eword_reg;
        vs_next       = vs_reg;
        res_valid     = 1'b0;
        res           = '0;
        idx_inc       = {1'b0, idx_reg} + 11'd1;
        ls            = ls_reg;
        rs            = rs_reg;
        vs            = vs_reg;

        if (fire)
        begin
            if (hc_reg < cmas_pkg::HDR_BYTES)
            begin
                case (hc_reg)
                    cmas_pkg::HDR_NS_HI: seq_sent_next = {data_byte, 8'h00};
                    cmas_pkg::HDR_NS_LO: seq_sent_next = {seq_sent_reg[15:8], data_byte};
                    cmas_pkg::HDR_NR_HI: seq_recv_next = {data_byte, 8'h00};
                    cmas_pkg::HDR_NR_LO: seq_recv_next = {seq_recv_reg[15:8], data_byte};
                    default: ;
                endcase
                hc_next = hc_reg + 4'd1;
            end
            else if (!broken_reg)
            begin
                case (idx_reg)
                    cmas_pkg::AVP_LEN_HI:  len_next  = {data_byte[1:0], 8'h00};
                    cmas_pkg::AVP_LEN_LO:  len_next  = len_reg | {2'b00, data_byte};
                    cmas_pkg::AVP_TYPE_HI: type_next = {data_byte, 8'h00};
                    cmas_pkg::AVP_TYPE_LO: type_next = type_reg | {8'h00, data_byte};
                    cmas_pkg::AVP_W1_HI:   w1_next   = {data_byte, 8'h00};
                    cmas_pkg::AVP_W1_LO:   w1_next   = w1_reg | {8'h00, data_byte};
                    cmas_pkg::AVP_W2_HI:   w2_next   = {data_byte, 8'h00};
                    cmas_pkg::AVP_W2_LO:   w2_next   = w2_reg | {8'h00, data_byte};
                    default: ;
                endcase

                if (idx_inc == {1'b0, cmas_pkg::MIN_AVP} && len_next < cmas_pkg::MIN_AVP)
                begin
                    // drop the rest of the walk
                    broken_next = 1'b1;
                    if (ls_reg == cmas_pkg::ST_PENDING) ls_next = cmas_pkg::ST_MALFORMED;
                    if (rs_reg == cmas_pkg::ST_PENDING) rs_next = cmas_pkg::ST_MALFORMED;
                    if (vs_reg == cmas_pkg::VD_PENDING) vs_next = cmas_pkg::VD_FAIL;
                    idx_next = idx_inc[9:0];
                end
                else if (idx_inc >= {1'b0, cmas_pkg::MIN_AVP} && idx_inc == {1'b0, len_next})
                begin
                    if (ls_reg == cmas_pkg::ST_PENDING && type_next == lookup_attr_type
                        && len_next >= cmas_pkg::MIN_WORD)
                    begin
                        ls_next    = cmas_pkg::ST_FOUND;
                        lword_next = w1_next;
                    end
                    if (type_next == cmas_pkg::RESULT_TYPE)
                    begin
                        if (rs_reg == cmas_pkg::ST_PENDING)
                        begin
                            if (len_next < cmas_pkg::MIN_WORD)
                            begin
                                rs_next = cmas_pkg::ST_MALFORMED;
                            end
                            else
                            begin
                                rs_next    = cmas_pkg::ST_FOUND;
                                rword_next = w1_next;
                                eword_next = (len_next >= cmas_pkg::MIN_TWO) ? w2_next : 16'h0000;
                            end
                        end
                        if (vs_reg == cmas_pkg::VD_PENDING)
                        begin
                            vs_next = (len_next < cmas_pkg::MIN_TWO || w1_next != 16'h0000)
                                      ? cmas_pkg::VD_FAIL : cmas_pkg::VD_PASS;
                        end
                    end
                    idx_next  = '0;
                    len_next  = '0;
                    type_next = '0;
                    w1_next   = '0;
                    w2_next   = '0;
                end
                else
                begin
                    idx_next = idx_inc[9:0];
                end
            end

            if (last_byte)
            begin
                res_valid = 1'b1;
                if (hc_next < cmas_pkg::HDR_BYTES)
                begin
                    res.header_ok      = 1'b0;
                    res.lookup_status  = cmas_pkg::ST_MALFORMED;
                    res.result_status  = cmas_pkg::ST_MALFORMED;
                    res.result_verdict = 1'b1;
                end
                else
                begin
                    ls = ls_next;
                    rs = rs_next;
                    vs = vs_next;
                    // overrun: message ended inside an AVP past its fixed part
                    if (!broken_next && idx_next >= cmas_pkg::MIN_AVP)
                    begin
                        if (ls == cmas_pkg::ST_PENDING) ls = cmas_pkg::ST_MALFORMED;
                        if (rs == cmas_pkg::ST_PENDING) rs = cmas_pkg::ST_MALFORMED;
                        if (vs == cmas_pkg::VD_PENDING) vs = cmas_pkg::VD_FAIL;
                    end
                    if (ls == cmas_pkg::ST_PENDING) ls = cmas_pkg::ST_ABSENT;
                    if (rs == cmas_pkg::ST_PENDING) rs = cmas_pkg::ST_ABSENT;
                    if (vs == cmas_pkg::VD_PENDING) vs = cmas_pkg::VD_PASS;
                    res.header_ok         = 1'b1;
                    res.sequence_sent     = seq_sent_next;
                    res.sequence_received = seq_recv_next;
                    res.lookup_status     = ls;
                    res.lookup_value      = (ls == cmas_pkg::ST_FOUND) ? lword_next : 16'h0000;
                    res.result_status     = rs;
                    res.outcome_code      = (rs == cmas_pkg::ST_FOUND) ? rword_next : 16'h0000;
                    res.detail_code       = (rs == cmas_pkg::ST_FOUND) ? eword_next : 16'h0000;
                    res.result_verdict    = vs[0];
                end

                // clear per-message state
                hc_next       = '0;
                seq_sent_next = '0;
                seq_recv_next = '0;
                idx_next      = '0;
                len_next      = '0;
                type_next     = '0;
                w1_next       = '0;
                w2_next       = '0;
                broken_next   = 1'b0;
                ls_next       = cmas_pkg::ST_PENDING;
                lword_next    = '0;
                rs_next       = cmas_pkg::ST_PENDING;
                rword_next    = '0;
                eword_next    = '0;
                vs_next       = cmas_pkg::VD_PENDING;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg       <= '0;
            seq_sent_reg <= '0;
            seq_recv_reg <= '0;
            idx_reg      <= '0;
            len_reg      <= '0;
            type_reg     <= '0;
            w1_reg       <= '0;
            w2_reg       <= '0;
            broken_reg   <= 1'b0;
            ls_reg       <= cmas_pkg::ST_PENDING;
            lword_reg    <= '0;
            rs_reg       <= cmas_pkg::ST_PENDING;
            rword_reg    <= '0;
            eword_reg    <= '0;
            vs_reg       <= cmas_pkg::VD_PENDING;
        end
        else
        begin
            hc_reg       <= hc_next;
            seq_sent_reg <= seq_sent_next;
            seq_recv_reg <= seq_recv_next;
            idx_reg      <= idx_next;
            len_reg      <= len_next;
            type_reg     <= type_next;
            w1_reg       <= w1_next;
            w2_reg       <= w2_next;
            broken_reg   <= broken_next;
            ls_reg       <= ls_next;
            lword_reg    <= lword_next;
            rs_reg       <= rs_next;
            rword_reg    <= rword_next;
            eword_reg    <= eword_next;
            vs_reg       <= vs_next;
        end
    end

endmodule
